// ----- sv/llem_pkg.sv -----
// ----------------------------------------------------------------------------
// llem_pkg
// Shared types and constants of the lat-long environment map texel access.
// ----------------------------------------------------------------------------
package llem_pkg;

  localparam int unsigned AngW = 34;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [31:0]        write_red;
    logic [31:0]        write_green;
    logic [31:0]        write_blue;
  } req_t;

  typedef struct packed {
    logic [31:0] read_red;
    logic [31:0] read_green;
    logic [31:0] read_blue;
    logic [8:0]  column_index;
    logic [7:0]  row_index;
    logic        did_write;
  } rsp_t;

  // Front-end states.
  typedef enum logic [2:0] {
    FS_IDLE,
    FS_SQRT,
    FS_AZ,
    FS_EL,
    FS_IDX,
    FS_PUSH
  } front_state_e;

  // Back-end states.
  typedef enum logic [1:0] {
    BS_IDLE,
    BS_READ,
    BS_OUT
  } back_state_e;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [AngW-1:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return {2'b00, v};
  endfunction

endpackage

// ----- sv/latlong_env_map_texel_access.sv -----
// ----------------------------------------------------------------------------
// latlong_env_map_texel_access
// Equirectangular environment map lookup with texel read and write.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// command   in         start_i, busy_o, req_i
// result    out        done_o, rsp_o
// config    in         cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// One transaction keeps the front end busy through the 24-step square root
// after its load cycle, the azimuth and elevation passes of the shared CORDIC
// datapath, the index state and the push, which waits while the queue is full;
// the next command is taken only once the front end is idle. The back end
// passes each access through its read and output states to the result strobe.
// Reset clears control state only; the texel memory is undefined until written.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module latlong_env_map_texel_access
  import llem_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = 512,
  parameter int unsigned MAX_HEIGHT   = 256,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT);
  localparam int unsigned QW   = ColW + RowW + $bits(req_t);

  logic [9:0] map_width_q;
  logic [8:0] map_height_q;
  logic            push, full, pop, qvalid;
  logic [ColW-1:0] f_col, q_col;
  logic [RowW-1:0] f_row, q_row;
  req_t            f_req, q_req;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= 10'd512;
      map_height_q <= 9'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MAP_WIDTH:  map_width_q  <= cfg_data_i[9:0];
        REG_MAP_HEIGHT: map_height_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  llem_front #(
    .MaxWidth    (MAX_WIDTH),
    .MaxHeight   (MAX_HEIGHT),
    .CordicSteps (CORDIC_STEPS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .req_i        (req_i),
    .busy_o       (busy_o),
    .map_width_i  (map_width_q),
    .map_height_i (map_height_q),
    .push_o       (push),
    .full_i       (full),
    .col_o        (f_col),
    .row_o        (f_row),
    .req_o        (f_req)
  );

  llem_queue #(
    .Width (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_col, f_row, f_req}),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (qvalid),
    .data_o  ({q_col, q_row, q_req})
  );

  llem_back #(
    .MaxWidth  (MAX_WIDTH),
    .MaxHeight (MAX_HEIGHT)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (qvalid),
    .col_i   (q_col),
    .row_i   (q_row),
    .req_i   (q_req),
    .pop_o   (pop),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

endmodule

// ----- sv/llem_ram.sv -----
// ----------------------------------------------------------------------------
// llem_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module llem_ram #(
  parameter int unsigned Width = 96,
  parameter int unsigned Depth = 131072
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- sv/llem_front.sv -----
// ----------------------------------------------------------------------------
// llem_front
// Maps a direction to column and row: integer square root, two CORDIC
// passes on one shared datapath, then scaling of both fractions.
// ----------------------------------------------------------------------------
module llem_front
  import llem_pkg::*;
#(
  parameter int unsigned MaxWidth    = 512,
  parameter int unsigned MaxHeight   = 256,
  parameter int unsigned CordicSteps = 16,
  localparam int unsigned ColW = $clog2(MaxWidth),
  localparam int unsigned RowW = $clog2(MaxHeight)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  req_t            req_i,
  output logic            busy_o,
  input  logic [9:0]      map_width_i,
  input  logic [8:0]      map_height_i,
  output logic            push_o,
  input  logic            full_i,
  output logic [ColW-1:0] col_o,
  output logic [RowW-1:0] row_o,
  output req_t            req_o
);

  localparam logic [4:0] LastStep = 5'(CordicSteps - 1);
  localparam int unsigned VecW = 42;
  localparam logic signed [AngW-1:0] Half = 34'sh080000000;
  localparam logic signed [AngW-1:0] Quarter = 34'sh040000000;
  // The square root first loads the operand, then steps the
  // trial bit down from 2^46 to 2^0.
  localparam logic [5:0] SqLoad = 6'd24;

  front_state_e st_q, st_d;
  req_t         req_q;
  logic [4:0]   cnt_q;
  // Square root working registers.
  logic [47:0]  n_q, root_q;
  logic [5:0]   sq_q;
  logic signed [VecW-1:0] a_q, b_q;
  logic signed [AngW-1:0] ang_q, az_q;
  logic [32:0]  u_q, v_q;

  logic signed [31:0] xx, zz;
  logic [32:0]  mag2;
  logic [47:0]  sq_bit, sq_trial;
  logic signed [VecW-1:0] sha, shb;
  logic signed [AngW-1:0] az_c, el_c, ang_n;
  logic [9:0]   w_eff;
  logic [8:0]   h_eff;
  logic [43:0]  col_p;
  logic [42:0]  row_p;
  logic signed [VecW-1:0] ax, bz;

  assign xx   = 32'(req_q.dir_x) * 32'(req_q.dir_x);
  assign zz   = 32'(req_q.dir_z) * 32'(req_q.dir_z);
  assign mag2 = 33'(xx) + 33'(zz);
  assign sq_bit   = 48'd1 << {sq_q, 1'b0};
  assign sq_trial = root_q + sq_bit;
  assign sha = a_q >>> cnt_q;
  assign shb = b_q >>> cnt_q;
  assign ax  = VecW'(req_q.dir_x) <<< 8;
  assign bz  = VecW'(req_q.dir_z) <<< 8;

  always_comb begin
    if (b_q >= 0) begin
      ang_n = ang_q + atan_turns(cnt_q);
    end else begin
      ang_n = ang_q - atan_turns(cnt_q);
    end
  end

  always_comb begin
    az_c = az_q;
    if (az_q > Half) az_c = Half;
    if (az_q < -Half) az_c = -Half;
    el_c = ang_q;
    if (ang_q > Quarter) el_c = Quarter;
    if (ang_q < -Quarter) el_c = -Quarter;
  end

  always_comb begin
    w_eff = map_width_i;
    if (map_width_i < 10'd2) w_eff = 10'd2;
    else if (32'(map_width_i) > MaxWidth) w_eff = 10'(MaxWidth);
    h_eff = map_height_i;
    if (map_height_i < 9'd2) h_eff = 9'd2;
    else if (32'(map_height_i) > MaxHeight) h_eff = 9'(MaxHeight);
  end

  assign col_p = 44'(u_q) * 44'(w_eff - 10'd1) + 44'h080000000;
  assign row_p = 43'(v_q) * 43'(h_eff - 9'd1) + 43'h080000000;

  always_comb begin
    st_d = st_q;
    case (st_q)
      FS_IDLE: if (start_i) st_d = FS_SQRT;
      FS_SQRT: if (sq_q == 6'd0) st_d = FS_AZ;
      FS_AZ:   if (cnt_q == LastStep) st_d = FS_EL;
      FS_EL:   if (cnt_q == LastStep) st_d = FS_IDX;
      FS_IDX:  st_d = FS_PUSH;
      FS_PUSH: if (!full_i) st_d = FS_IDLE;
      default: st_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= FS_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk_i) begin
    case (st_q)
      FS_IDLE: begin
        if (start_i) req_q <= req_i;
        sq_q <= SqLoad;
        root_q <= '0;
      end
      FS_SQRT: begin
        if (sq_q == SqLoad) begin
          n_q  <= 48'(mag2) << 16;
          sq_q <= SqLoad - 6'd1;
        end else begin
          if (n_q >= sq_trial) begin
            n_q    <= n_q - sq_trial;
            root_q <= (root_q >> 1) + sq_bit;
          end else begin
            root_q <= root_q >> 1;
          end
          sq_q <= sq_q - 6'd1;
        end
        cnt_q <= '0;
        a_q <= (ax < 0) ? -ax : ax;
        b_q <= (ax < 0) ? -bz : bz;
        ang_q <= (ax < 0) ? ((bz >= 0) ? Half : -Half) : '0;
      end
      FS_AZ: begin
        if (cnt_q == LastStep) begin
          cnt_q <= '0;
          az_q  <= (req_q.dir_x == 0 && req_q.dir_z == 0) ? '0 : ang_n;
          ang_q <= '0;
          a_q   <= VecW'(root_q);
          b_q   <= VecW'(req_q.dir_y) <<< 8;
        end else begin
          a_q   <= (b_q >= 0) ? a_q + shb : a_q - shb;
          b_q   <= (b_q >= 0) ? b_q - sha : b_q + sha;
          ang_q <= ang_n;
          cnt_q <= cnt_q + 5'd1;
        end
      end
      FS_EL: begin
        a_q   <= (b_q >= 0) ? a_q + shb : a_q - shb;
        b_q   <= (b_q >= 0) ? b_q - sha : b_q + sha;
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == LastStep && root_q == '0 && req_q.dir_y == 0) begin
          ang_q <= '0;
        end else begin
          ang_q <= ang_n;
        end
      end
      FS_IDX: begin
        u_q <= 33'(az_c + Half);
        v_q <= 33'((el_c <<< 1) + Half);
      end
      default: ;
    endcase
  end

  assign busy_o = (st_q != FS_IDLE);
  assign push_o = (st_q == FS_PUSH) && !full_i;
  assign col_o  = col_p[32 +: ColW];
  assign row_o  = row_p[32 +: RowW];
  assign req_o  = req_q;

endmodule

// ----- sv/llem_queue.sv -----
// ----------------------------------------------------------------------------
// llem_queue
// Two-entry queue of classified transactions between front and back end.
// ----------------------------------------------------------------------------
module llem_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] mem_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// ----- sv/llem_back.sv -----
// ----------------------------------------------------------------------------
// llem_back
// Executes texel reads and writes against the map memory.
// ----------------------------------------------------------------------------
module llem_back
  import llem_pkg::*;
#(
  parameter int unsigned MaxWidth  = 512,
  parameter int unsigned MaxHeight = 256,
  localparam int unsigned ColW  = $clog2(MaxWidth),
  localparam int unsigned RowW  = $clog2(MaxHeight),
  localparam int unsigned AddrW = ColW + RowW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [ColW-1:0] col_i,
  input  logic [RowW-1:0] row_i,
  input  req_t            req_i,
  output logic            pop_o,
  output logic            done_o,
  output rsp_t            rsp_o
);

  back_state_e st_q, st_d;
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic            wr_q;
  logic [95:0]     rdata;
  logic            we;

  assign pop_o = (st_q == BS_IDLE) && valid_i;
  assign we    = pop_o && (req_i.cmd == CMD_WRITE);

  llem_ram #(
    .Width (96),
    .Depth (2 ** AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  ({row_i, col_i}),
    .wdata_i ({req_i.write_red, req_i.write_green, req_i.write_blue}),
    .rdata_o (rdata)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      BS_IDLE: if (valid_i) st_d = BS_READ;
      BS_READ: st_d = BS_OUT;
      BS_OUT:  st_d = BS_IDLE;
      default: st_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BS_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      col_q <= col_i;
      row_q <= row_i;
      wr_q  <= req_i.cmd;
    end
    if (st_q == BS_READ) begin
      rsp_o.did_write    <= wr_q;
      rsp_o.column_index <= 9'(col_q);
      rsp_o.row_index    <= 8'(row_q);
      {rsp_o.read_red, rsp_o.read_green, rsp_o.read_blue} <= wr_q ? 96'd0 : rdata;
    end
  end

  assign done_o = (st_q == BS_OUT);

endmodule
